>>> design/hv_channel_monitor_scheduler_defines.svh
// Assertion macros for the high-voltage channel supervisor.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef HV_CHANNEL_MONITOR_SCHEDULER_DEFINES_SVH
`define HV_CHANNEL_MONITOR_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define HVCMS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HVCMS_NEVER(label, cond, msg) \
	`HVCMS_ASSERT(label, !(cond), msg)
`else
`define HVCMS_ASSERT(label, prop, msg)
`define HVCMS_NEVER(label, cond, msg)
`endif
`endif

>>> design/hvcms_pkg.sv
// Shared types, codes and constants for the high-voltage channel supervisor.
// No dependencies.
package hvcms_pkg;

	localparam int VOLT_W   = 13;
	localparam int MS_W     = 32;
	localparam int COUNT_W  = 6;
	localparam int SENS_W   = 10;
	localparam int ACT_W    = 3;
	localparam int CHIN_W   = 5;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	typedef logic [VOLT_W-1:0] volt_t;
	typedef logic [MS_W-1:0]   ms_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE    = 3'd0,
		ACT_SET     = 3'd1,
		ACT_PUBLISH = 3'd2,
		ACT_READ    = 3'd3,
		ACT_ON      = 3'd4,
		ACT_OFF     = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		KIND_DEMAND = 2'd0,
		KIND_MEAS   = 2'd1,
		KIND_POLL   = 2'd2,
		KIND_SWITCH = 2'd3
	} kind_t;

	localparam logic [1:0] REG_COUNT = 2'd0;
	localparam logic [1:0] REG_LIMIT = 2'd1;
	localparam logic [1:0] REG_SENS  = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_RST = 6'd32;
	localparam volt_t              LIMIT_RST = 13'd3000;
	localparam logic [SENS_W-1:0]  SENS_RST  = 10'd3;

	localparam ms_t RECENT_MS = 32'd5000;
	localparam ms_t STALE_MS  = 32'd20000;
	localparam ms_t FRESH_MS  = 32'd2000;

	typedef struct packed {
		volt_t demand;
		volt_t sent;
		volt_t meas;
		volt_t pub;
		ms_t   stamp;
	} entry_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		volt_t              limit;
		logic [SENS_W-1:0]  sens;
	} cfg_t;

	typedef struct packed {
		volt_t clamped;
		logic  set_differs;
		volt_t dev;
		logic  dev_gt_max;
		logic  max_ge_sens;
		logic  fresh;
		logic  qualifies;
	} alu_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEM_RD,
		ST_DEM_WR,
		ST_MEAS_RD,
		ST_MEAS_WR,
		ST_SCAN,
		ST_PUB,
		ST_POLL_MOD,
		ST_POLL,
		ST_DONE
	} state_t;

endpackage

>>> design/hvcms_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hvcms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/hvcms_alu.sv
// Shared compare unit: clamp, deviations, channel age tests on one entry.
// Depends on hvcms_pkg.
module hvcms_alu (
	input  hvcms_pkg::entry_t   entry,
	input  hvcms_pkg::ms_t      now_ms,
	input  hvcms_pkg::volt_t    volts,
	input  hvcms_pkg::cfg_t     cfg,
	input  hvcms_pkg::volt_t    max_dev,
	output hvcms_pkg::alu_res_t res
);

	import hvcms_pkg::*;

	function automatic volt_t absd(input volt_t a, input volt_t b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	ms_t   age;
	volt_t off;
	volt_t sens_v;
	volt_t sens2_v;

	always_comb begin
		age     = now_ms - entry.stamp;
		off     = absd(entry.meas, entry.demand);
		sens_v  = VOLT_W'(cfg.sens);
		sens2_v = {2'b00, cfg.sens, 1'b0};

		res.clamped     = (volts > cfg.limit) ? cfg.limit : volts;
		res.set_differs = res.clamped != entry.sent;
		res.dev         = absd(entry.meas, entry.pub);
		res.dev_gt_max  = res.dev > max_dev;
		res.max_ge_sens = max_dev >= sens_v;
		res.fresh       = age < FRESH_MS;
		res.qualifies   = (age < RECENT_MS) || ((age < STALE_MS) && (off > sens2_v));
	end

endmodule

>>> design/hvcms_cfg.sv
// APB-style configuration registers: channel count, voltage limit, sensitivity.
// Depends on hvcms_pkg.
module hvcms_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [hvcms_pkg::PADDR_W-1:0]       paddr,
	input  logic [hvcms_pkg::PDATA_W-1:0]       pwdata,
	output logic [hvcms_pkg::PDATA_W-1:0]       prdata,
	output logic                                pready,
	output hvcms_pkg::cfg_t                     cfg
);

	import hvcms_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count <= COUNT_RST;
			cfg_q.limit <= LIMIT_RST;
			cfg_q.sens  <= SENS_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_COUNT: cfg_q.count <= pwdata[COUNT_W-1:0];
				REG_LIMIT: cfg_q.limit <= pwdata[VOLT_W-1:0];
				REG_SENS:  cfg_q.sens  <= pwdata[SENS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_COUNT: prdata = PDATA_W'(cfg_q.count);
			REG_LIMIT: prdata = PDATA_W'(cfg_q.limit);
			REG_SENS:  prdata = PDATA_W'(cfg_q.sens);
			default:   prdata = '0;
		endcase
	end

endmodule

>>> design/hv_channel_monitor_scheduler.sv
// High-voltage channel supervisor, top level: sequencer, channel RAM, valid bits,
// result register. Depends on hvcms_pkg, hvcms_cfg, hvcms_alu, hvcms_ram.
// One transaction is worked on at a time; in_ready is high only while the sequencer
// idles. A finished result waits in the output register; the next transaction can be
// accepted meanwhile but cannot finish until that result is taken. Every channel record
// sits in one RAM word read once per cycle, so the cost is set by that read port: a
// demand reads and writes its record, a switch or out-of-range item goes straight to the
// result, a measurement writes its record and scans the channels in use for the largest
// deviation, scanning again when it publishes; a poll wraps its start channel first.
// Reset clears the per-channel valid bits at once, so no clearing pass is needed.
`include "hv_channel_monitor_scheduler_defines.svh"

module hv_channel_monitor_scheduler #(
	parameter int MAX_CHANNELS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [hvcms_pkg::PADDR_W-1:0]      paddr,
	input  logic [hvcms_pkg::PDATA_W-1:0]      pwdata,
	output logic [hvcms_pkg::PDATA_W-1:0]      prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         kind,
	input  logic [hvcms_pkg::CHIN_W-1:0]       channel,
	input  hvcms_pkg::volt_t                   volts,
	input  hvcms_pkg::ms_t                     now_ms,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [hvcms_pkg::ACT_W-1:0]        action,
	output logic [hvcms_pkg::CHIN_W-1:0]       target_channel,
	output hvcms_pkg::volt_t                   set_volts
);

	import hvcms_pkg::*;

	localparam int CH_W  = $clog2(MAX_CHANNELS);
	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
	localparam int ENT_W = $bits(entry_t);
	localparam logic [6:0] MAX7 = 7'(MAX_CHANNELS);

	cfg_t     cfg;
	alu_res_t alu;

	state_t state_q, state_d;

	logic [CH_W-1:0]  ch_q;
	volt_t            volts_q;
	ms_t              now_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] rp_q;
	logic [CNT_W-1:0] iss_q;
	logic [CNT_W-1:0] evc_q;
	logic [CNT_W-1:0] v_q;
	logic [CH_W-1:0]  first_q;
	logic [CH_W-1:0]  last_q;
	logic             ev_s1;
	logic [CH_W-1:0]  ep_s1;
	logic             rvld_s1;
	volt_t            max_q;
	logic             fresh_q;

	action_t          pend_act_q;
	logic [CH_W-1:0]  pend_tgt_q;
	volt_t            pend_setv_q;
	logic             out_valid_q;
	action_t          action_q;
	logic [CH_W-1:0]  target_q;
	volt_t            set_volts_q;

	logic [MAX_CHANNELS-1:0] vld_q;

	logic             ram_we;
	logic [CH_W-1:0]  ram_waddr;
	entry_t           ram_wdata;
	logic [CH_W-1:0]  ram_raddr;
	logic [ENT_W-1:0] ram_rdata;
	entry_t           entry;

	logic [6:0]       cc7;
	logic [6:0]       n7;
	logic [CNT_W-1:0] n_now;
	logic             in_range;
	logic             acc;
	logic             scan_issue;
	logic             scan_end;
	logic             pub_go;
	logic             mod_done;
	logic             poll_issue;
	logic [CNT_W-1:0] rp_inc;
	logic [CNT_W-1:0] rp_next;
	logic [CNT_W-1:0] ep_inc;
	logic [CH_W-1:0]  nxt_ep;
	logic             poll_hit;
	logic             poll_end;
	logic             out_load;

	hvcms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hvcms_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// never-written records read as zero
	assign entry = rvld_s1 ? entry_t'(ram_rdata) : '0;

	hvcms_alu u_alu (
		.entry   (entry),
		.now_ms  (now_q),
		.volts   (volts_q),
		.cfg     (cfg),
		.max_dev (max_q),
		.res     (alu)
	);

	always_comb begin
		cc7        = {1'b0, cfg.count};
		n7         = (cc7 == 7'd0) ? 7'd1 : ((cc7 > MAX7) ? MAX7 : cc7);
		n_now      = CNT_W'(n7);
		in_range   = {2'b00, channel} < n7;
		acc        = in_valid && in_ready;
		scan_issue = rp_q < n_q;
		scan_end   = !scan_issue && !ev_s1;
		pub_go     = alu.max_ge_sens || (fresh_q && (max_q != '0));
		mod_done   = v_q < n_q;
		poll_issue = iss_q < n_q;
		rp_inc     = rp_q + CNT_W'(1);
		rp_next    = (rp_inc == n_q) ? '0 : rp_inc;
		ep_inc     = CNT_W'(ep_s1) + CNT_W'(1);
		nxt_ep     = (ep_inc == n_q) ? '0 : ep_inc[CH_W-1:0];
		poll_hit   = ev_s1 && alu.qualifies;
		poll_end   = poll_hit || (ev_s1 && !alu.qualifies &&
			((nxt_ep == last_q) || ((evc_q + CNT_W'(1)) == n_q)));
		out_load   = !out_valid_q || out_ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (kind_t'(kind))
						KIND_DEMAND: state_d = in_range ? ST_DEM_RD : ST_DONE;
						KIND_MEAS:   state_d = in_range ? ST_MEAS_RD : ST_DONE;
						KIND_POLL:   state_d = ST_POLL_MOD;
						KIND_SWITCH: state_d = ST_DONE;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_DEM_RD:   state_d = ST_DEM_WR;
			ST_DEM_WR:   state_d = ST_DONE;
			ST_MEAS_RD:  state_d = ST_MEAS_WR;
			ST_MEAS_WR:  state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_end) begin
					state_d = pub_go ? ST_PUB : ST_DONE;
				end
			end
			ST_PUB: begin
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_POLL_MOD: begin
				if (mod_done) begin
					state_d = ST_POLL;
				end
			end
			ST_POLL: begin
				if (poll_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		ram_raddr = rp_q[CH_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = ep_s1;
		ram_wdata = entry;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_DEM_RD, ST_MEAS_RD: ram_raddr = ch_q;
			ST_DEM_WR: begin
				ram_we           = 1'b1;
				ram_waddr        = ch_q;
				ram_wdata.demand = alu.clamped;
				if (alu.set_differs) begin
					ram_wdata.sent  = alu.clamped;
					ram_wdata.stamp = now_q;
				end
			end
			ST_MEAS_WR: begin
				ram_we         = 1'b1;
				ram_waddr      = ch_q;
				ram_wdata.meas = volts_q;
			end
			ST_PUB: begin
				ram_we        = ev_s1;
				ram_wdata.pub = entry.meas;
			end
			ST_SCAN, ST_POLL_MOD, ST_POLL, ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
			last_q      <= '0;
			rvld_s1     <= 1'b0;
			ev_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			rvld_s1 <= vld_q[ram_raddr];
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (state_q == ST_DONE && out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_POLL && poll_end) begin
				last_q <= poll_hit ? ep_s1 : first_q;
			end
			unique case (state_q)
				ST_SCAN, ST_PUB: ev_s1 <= scan_issue;
				ST_POLL:         ev_s1 <= poll_issue && !poll_end;
				default:         ev_s1 <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ch_q        <= CH_W'(channel);
			volts_q     <= volts;
			now_q       <= now_ms;
			n_q         <= n_now;
			v_q         <= CNT_W'(last_q) + CNT_W'(1);
			pend_act_q  <= (kind_t'(kind) == KIND_SWITCH) ?
				((volts != '0) ? ACT_ON : ACT_OFF) : ACT_NONE;
			pend_tgt_q  <= '0;
			pend_setv_q <= '0;
		end
		case (state_q)
			ST_DEM_WR: begin
				if (alu.set_differs) begin
					pend_act_q  <= ACT_SET;
					pend_tgt_q  <= ch_q;
					pend_setv_q <= alu.clamped;
				end
			end
			ST_MEAS_WR: begin
				rp_q    <= '0;
				max_q   <= '0;
				fresh_q <= 1'b0;
			end
			ST_SCAN, ST_PUB: begin
				if (scan_issue) begin
					rp_q  <= rp_q + CNT_W'(1);
					ep_s1 <= rp_q[CH_W-1:0];
				end
				if (state_q == ST_SCAN && ev_s1) begin
					if (alu.dev_gt_max) begin
						max_q <= alu.dev;
					end
					if (alu.fresh) begin
						fresh_q <= 1'b1;
					end
				end
				if (scan_end) begin
					rp_q <= '0;
					if (state_q == ST_PUB) begin
						pend_act_q <= ACT_PUBLISH;
					end
				end
			end
			ST_POLL_MOD: begin
				if (!mod_done) begin
					v_q <= v_q - n_q;
				end else begin
					first_q <= v_q[CH_W-1:0];
					rp_q    <= v_q;
					iss_q   <= '0;
					evc_q   <= '0;
				end
			end
			ST_POLL: begin
				if (poll_issue) begin
					rp_q  <= rp_next;
					iss_q <= iss_q + CNT_W'(1);
					ep_s1 <= rp_q[CH_W-1:0];
				end
				if (ev_s1 && !alu.qualifies) begin
					evc_q <= evc_q + CNT_W'(1);
				end
				if (poll_end) begin
					pend_act_q <= ACT_READ;
					pend_tgt_q <= poll_hit ? ep_s1 : first_q;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					action_q    <= pend_act_q;
					target_q    <= pend_tgt_q;
					set_volts_q <= pend_setv_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign action         = action_q;
	assign target_channel = CHIN_W'(target_q);
	assign set_volts      = set_volts_q;

	`HVCMS_ASSERT(a_set_clamped, (out_valid_q && action_q == ACT_SET) |-> (set_volts_q <= cfg.limit), "set command above voltage limit")
	`HVCMS_ASSERT(a_poll_in_use, (state_q == ST_POLL && state_d == ST_DONE) |=> (CNT_W'(last_q) < n_q), "polled channel outside count in use")
	`HVCMS_NEVER(a_scan_bound, (state_q == ST_SCAN || state_q == ST_PUB) && (rp_q > n_q), "scan pointer past channel count")
	`HVCMS_NEVER(a_write_in_use, ram_we && (CNT_W'(ram_waddr) >= n_q), "RAM write to channel not in use")

endmodule
